[rtl/mbam_pkg.sv]
// Package for the main bus address map block: payload structs, region codes
// and address constants. Used by every module of the block.
package mbam_pkg;

   typedef struct packed {
      logic       op;
      logic [20:0] address;
      logic [7:0] write_data;
      logic [7:0] player1_port;
      logic [7:0] player2_port;
      logic [7:0] system_port;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        rom_select;
      logic        palette_valid;
      logic [9:0]  palette_index;
      logic [23:0] palette_rgb;
      logic        sound_nmi;
      logic [7:0]  sound_code;
      logic        sprite_copy;
      logic        ctrl_valid;
      logic [1:0]  ctrl_target;
      logic [1:0]  ctrl_position;
      logic [15:0] ctrl_word;
   } rsp_type;

   typedef enum logic [3:0] {
      RG_NONE, RG_ROM, RG_CTRL, RG_FRONT, RG_TEXT, RG_SPRITE, RG_COPY,
      RG_PAL, RG_LATCH, RG_RAM, RG_P1, RG_P2, RG_DIPA, RG_DIPB, RG_SYS
   } region_type;

   // classified access handed from front to back
   typedef struct packed {
      logic       op;
      region_type region;
      logic [20:0] address;
      logic [7:0] write_data;
      logic [7:0] port_data;
   } cmd_type;

   localparam logic [20:0] ROM_TOP   = 21'h02ffff;
   localparam logic [20:0] FRONT_LO  = 21'h062000;
   localparam logic [20:0] FRONT_HI  = 21'h063fff;
   localparam logic [20:0] TEXT_LO   = 21'h072000;
   localparam logic [20:0] TEXT_HI   = 21'h0727ff;
   localparam logic [20:0] SPR_LO    = 21'h100000;
   localparam logic [20:0] SPR_HI    = 21'h1007ff;
   localparam logic [20:0] COPY_ADR  = 21'h110000;
   localparam logic [20:0] PAL_LO    = 21'h120000;
   localparam logic [20:0] PAL_HI    = 21'h1205ff;
   localparam logic [20:0] PORT_ADR  = 21'h130000;
   localparam logic [20:0] SYS_ADR   = 21'h140000;
   localparam logic [20:0] LATCH_ADR = 21'h150000;
   localparam logic [20:0] RAM_LO    = 21'h1f0000;

   localparam logic CSR_DIPA = 1'b0;
   localparam logic CSR_DIPB = 1'b1;

endpackage

[rtl/mbam_front.sv]
// Front end: accepts bus accesses, decodes the address into a region code.
// Depends on mbam_pkg.
module mbam_front import mbam_pkg::*; #(
   parameter int RAM_BYTES    = 16384,
   parameter int LAYER1_WORDS = 4096,
   parameter int LAYER2_WORDS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    cmd_valid,
   input  logic    cmd_stall,
   output cmd_type cmd_data
);
   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   logic [20:0] a;
   logic [20:0] ram_off;
   logic [12:0] fk;
   logic [10:0] tk;
   logic ctrl_hit;

   assign a = req_data.address;
   assign ram_off = a - RAM_LO;
   assign fk = {1'b0, a[12:1]};
   assign tk = {1'b0, a[10:1]};
   assign ctrl_hit = (a[20:5] == 16'h3000 || a[20:5] == 16'h3800) &&
                     (a[4] || !a[3]);

   // region decode
   always_comb begin
      cmd_in.op         = req_data.op;
      cmd_in.address    = a;
      cmd_in.write_data = req_data.write_data;
      cmd_in.port_data  = 8'h00;
      cmd_in.region     = RG_NONE;
      if (!req_data.op && a <= ROM_TOP) cmd_in.region = RG_ROM;
      else if (req_data.op && ctrl_hit) cmd_in.region = RG_CTRL;
      else if (a >= FRONT_LO && a <= FRONT_HI) begin
         if (32'(fk) < LAYER1_WORDS) cmd_in.region = RG_FRONT;
      end else if (a >= TEXT_LO && a <= TEXT_HI) begin
         if (32'(tk) < LAYER2_WORDS) cmd_in.region = RG_TEXT;
      end else if (a >= SPR_LO && a <= SPR_HI) cmd_in.region = RG_SPRITE;
      else if (req_data.op && a == COPY_ADR) cmd_in.region = RG_COPY;
      else if (a >= PAL_LO && a <= PAL_HI) cmd_in.region = RG_PAL;
      else if (!req_data.op && a == PORT_ADR) begin
         cmd_in.region = RG_P1; cmd_in.port_data = req_data.player1_port;
      end else if (!req_data.op && a == PORT_ADR + 21'd1) begin
         cmd_in.region = RG_P2; cmd_in.port_data = req_data.player2_port;
      end else if (!req_data.op && a == PORT_ADR + 21'd2) cmd_in.region = RG_DIPA;
      else if (!req_data.op && a == PORT_ADR + 21'd3) cmd_in.region = RG_DIPB;
      else if (!req_data.op && a == SYS_ADR) begin
         cmd_in.region = RG_SYS; cmd_in.port_data = req_data.system_port;
      end else if (req_data.op && a == LATCH_ADR) cmd_in.region = RG_LATCH;
      else if (a >= RAM_LO && 32'(ram_off) < RAM_BYTES) cmd_in.region = RG_RAM;
   end

   // one-entry queue toward the back end
   assign req_stall = valid_ff && cmd_stall;
   assign valid_in  = req_valid || (valid_ff && cmd_stall);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!req_stall) cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd_data  = cmd_ff;
endmodule

[rtl/mbam_back.sv]
// Back end: holds the stores, performs reads and writes, builds results.
// Depends on mbam_pkg. Stores clear by a sweep after reset.
module mbam_back import mbam_pkg::*; #(
   parameter int RAM_BYTES    = 16384,
   parameter int LAYER1_WORDS = 4096,
   parameter int LAYER2_WORDS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_stall,
   input  cmd_type    cmd_data,
   input  logic [7:0] dip_a,
   input  logic [7:0] dip_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);
   localparam int RAW = $clog2(RAM_BYTES);
   localparam int F1W = $clog2(LAYER1_WORDS);
   localparam int F2W = $clog2(LAYER2_WORDS);
   // sweep covers the deepest store
   localparam int CLR_A = RAM_BYTES > 2048 ? RAM_BYTES : 2048;
   localparam int CLR_B = LAYER1_WORDS > LAYER2_WORDS ? LAYER1_WORDS : LAYER2_WORDS;
   localparam int CLR_MAX = CLR_A > CLR_B ? CLR_A : CLR_B;
   localparam int CLW = $clog2(CLR_MAX + 1);

   logic [7:0]  ram_mem [RAM_BYTES];
   logic [7:0]  spr_mem [2048];
   logic [15:0] pal_mem [768];
   logic [15:0] front_mem [LAYER1_WORDS];
   logic [15:0] text_mem [LAYER2_WORDS];
   logic [15:0] ctrl_ff [16];
   logic [7:0]  latch_ff;

   logic [CLW-1:0] clr_ff;
   logic clearing;
   assign clearing = clr_ff != CLW'(CLR_MAX);

   // two-phase: read stage then write/result stage
   logic    s1_ff;
   cmd_type c1_ff;
   logic [7:0]  ram_q, spr_q;
   logic [15:0] pal_q, front_q, text_q;
   logic    out_ff;
   rsp_type rsp_ff, rsp_in;
   logic [7:0]  byte_sel;
   logic [15:0] merged;
   logic [3:0]  slot;
   logic [1:0]  tgt;

   // sequential: one access in flight
   assign cmd_stall = clearing || s1_ff || (out_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         s1_ff <= 1'b0;
      end else begin
         if (clearing) clr_ff <= clr_ff + 1'b1;
         s1_ff <= cmd_valid && !cmd_stall;
      end
      if (cmd_valid && !cmd_stall) c1_ff <= cmd_data;
   end

   // registered store reads
   always_ff @(posedge clock) begin
      ram_q   <= ram_mem[cmd_data.address[RAW-1:0]];
      spr_q   <= spr_mem[cmd_data.address[10:0]];
      pal_q   <= pal_mem[cmd_data.address[10:1] < 10'd768 ? cmd_data.address[10:1] : 10'd0];
      front_q <= front_mem[cmd_data.address[F1W:1]];
      text_q  <= text_mem[cmd_data.address[F2W:1]];
   end

   assign byte_sel = c1_ff.address[0] ? c1_ff.write_data : c1_ff.write_data;
   assign tgt  = {c1_ff.address[16], c1_ff.address[4]};
   assign slot = {tgt, c1_ff.address[2:1]};

   always_comb begin
      logic [15:0] w;
      w = 16'h0;
      case (c1_ff.region)
         RG_CTRL:  w = ctrl_ff[slot];
         RG_FRONT: w = front_q;
         RG_TEXT:  w = text_q;
         RG_PAL:   w = pal_q;
         default:  w = 16'h0;
      endcase
      merged = c1_ff.address[0] ? {byte_sel, w[7:0]} : {w[15:8], byte_sel};
   end

   // result build
   always_comb begin
      logic [15:0] pw;
      rsp_in = '0;
      pw = merged;
      if (!c1_ff.op) begin
         case (c1_ff.region)
            RG_ROM:    rsp_in.rom_select = 1'b1;
            RG_FRONT:  rsp_in.read_data = c1_ff.address[0] ? front_q[15:8] : front_q[7:0];
            RG_TEXT:   rsp_in.read_data = c1_ff.address[0] ? text_q[15:8] : text_q[7:0];
            RG_SPRITE: rsp_in.read_data = spr_q;
            RG_PAL:    rsp_in.read_data = c1_ff.address[0] ? pal_q[15:8] : pal_q[7:0];
            RG_P1, RG_P2, RG_SYS: rsp_in.read_data = c1_ff.port_data;
            RG_DIPA:   rsp_in.read_data = dip_a;
            RG_DIPB:   rsp_in.read_data = dip_b;
            RG_RAM:    rsp_in.read_data = ram_q;
            default:   rsp_in.read_data = 8'h00;
         endcase
      end else begin
         case (c1_ff.region)
            RG_CTRL: begin
               rsp_in.ctrl_valid = 1'b1;
               rsp_in.ctrl_target = tgt;
               rsp_in.ctrl_position = c1_ff.address[2:1];
               rsp_in.ctrl_word = merged;
            end
            RG_COPY:  rsp_in.sprite_copy = 1'b1;
            RG_LATCH: rsp_in.sound_nmi = 1'b1;
            RG_PAL: begin
               if (pw != pal_q) begin
                  rsp_in.palette_valid = 1'b1;
                  rsp_in.palette_index = c1_ff.address[10:1];
                  rsp_in.palette_rgb = {pw[3:0], pw[3:0], pw[7:4], pw[7:4],
                                        pw[11:8], pw[11:8]};
               end
            end
            default: rsp_in.ctrl_valid = 1'b0;
         endcase
      end
      rsp_in.sound_code = (c1_ff.op && c1_ff.region == RG_LATCH) ?
                          c1_ff.write_data : latch_ff;
   end

   // store writes and clearing sweep
   always_ff @(posedge clock) begin
      if (clearing) begin
         if (32'(clr_ff) < RAM_BYTES) ram_mem[clr_ff[RAW-1:0]] <= 8'h00;
         if (32'(clr_ff) < 2048) spr_mem[clr_ff[10:0]] <= 8'h00;
         if (32'(clr_ff) < 768) pal_mem[clr_ff[9:0]] <= 16'h0;
         if (32'(clr_ff) < LAYER1_WORDS) front_mem[clr_ff[F1W-1:0]] <= 16'h0;
         if (32'(clr_ff) < LAYER2_WORDS) text_mem[clr_ff[F2W-1:0]] <= 16'h0;
      end else if (s1_ff && c1_ff.op) begin
         case (c1_ff.region)
            RG_RAM:    ram_mem[c1_ff.address[RAW-1:0]] <= c1_ff.write_data;
            RG_SPRITE: spr_mem[c1_ff.address[10:0]] <= c1_ff.write_data;
            RG_PAL:    pal_mem[c1_ff.address[10:1]] <= merged;
            RG_FRONT:  front_mem[c1_ff.address[F1W:1]] <= merged;
            RG_TEXT:   text_mem[c1_ff.address[F2W:1]] <= merged;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 8'h00;
         out_ff <= 1'b0;
         for (int i = 0; i < 16; i++) ctrl_ff[i] <= 16'h0;
      end else begin
         if (s1_ff && c1_ff.op && c1_ff.region == RG_LATCH) latch_ff <= c1_ff.write_data;
         if (s1_ff && c1_ff.op && c1_ff.region == RG_CTRL) ctrl_ff[slot] <= merged;
         if (s1_ff) out_ff <= 1'b1;
         else if (!rsp_stall) out_ff <= 1'b0;
      end
      if (s1_ff) rsp_ff <= rsp_in;
   end

   assign rsp_valid = out_ff;
   assign rsp_data  = rsp_ff;

   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      s1_ff |-> !(cmd_valid && !cmd_stall)) else $error("two accesses in flight");
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> cmd_stall) else $error("access during clear sweep");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_ff |=> out_ff) else $error("result lost");
endmodule

[rtl/main_bus_address_map_top.sv]
// Main bus address map: after its request transfer, a request passes the front
// register, the store read and the result register in turn. The back end takes
// no new access while one is in its read stage, while clearing, or while stalled.
// Synchronous reset clears control state and starts a clearing sweep over the
// addresses of the deepest store, during which no access is taken.
// Depends on mbam_pkg, mbam_front, mbam_back.
module main_bus_address_map_top import mbam_pkg::*; #(
   parameter int RAM_BYTES    = 16384,
   parameter int LAYER1_WORDS = 4096,
   parameter int LAYER2_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0] dip_a_ff, dip_b_ff;
   logic    cmd_valid, cmd_stall;
   cmd_type cmd_data;

   // register file
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dip_a_ff <= 8'hff;
         dip_b_ff <= 8'hff;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         if (csr_paddr[2] == CSR_DIPA) dip_a_ff <= csr_pwdata[7:0];
         else dip_b_ff <= csr_pwdata[7:0];
      end
   end
   assign csr_prdata = {24'h0, csr_paddr[2] == CSR_DIPB ? dip_b_ff : dip_a_ff};

   mbam_front #(.RAM_BYTES(RAM_BYTES), .LAYER1_WORDS(LAYER1_WORDS),
                .LAYER2_WORDS(LAYER2_WORDS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_stall, .cmd_data);

   mbam_back #(.RAM_BYTES(RAM_BYTES), .LAYER1_WORDS(LAYER1_WORDS),
               .LAYER2_WORDS(LAYER2_WORDS)) u_back (
      .clock, .reset, .cmd_valid, .cmd_stall, .cmd_data,
      .dip_a(dip_a_ff), .dip_b(dip_b_ff), .rsp_valid, .rsp_stall, .rsp_data);
endmodule
